>>> rtl/i2cms_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cms_pkg: shared types and constants of the I2C master bit sequencer
// Holds the classified word format passed from the front stage to the
// sequencer core, the pending-flag and event-flag bit positions, the status
// codes and the configuration register indexes.
// ----------------------------------------------------------------------------
package i2cms_pkg;

    // Field widths of the stream words.
    localparam int DATA_W     = 10;
    localparam int FLAGS_W    = 5;
    localparam int STATUS_W   = 2;
    localparam int HALF_W     = 11;
    localparam int RDATA_W    = 8;
    localparam int S_TDATA_W  = 16;
    localparam int M_TDATA_W  = 24;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;

    // Working width for address framing before it is cut to the shift width.
    localparam int FRAME_W = 17;

    // Depth of the queue between the front stage and the sequencer core.
    localparam int QDEPTH = 2;
    localparam int Q_AW   = $clog2(QDEPTH);
    localparam int Q_CW   = $clog2(QDEPTH + 1);

    // Pending command flag positions.
    localparam int PD_START   = 0;
    localparam int PD_RESTART = 1;
    localparam int PD_STOP    = 2;
    localparam int PD_READ    = 3;
    localparam int PD_TEN     = 4;

    // Event flag positions, reported through the interrupt mask.
    localparam int EV_STARTED = 0;
    localparam int EV_ADDR    = 1;
    localparam int EV_TEN     = 2;
    localparam int EV_TXE     = 3;
    localparam int EV_NACK    = 4;

    // Command status codes.
    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_DISABLED = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BUSY     = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MASK   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HALF   = 2'd2;

    // Ten-bit address framing constants.
    localparam logic [FRAME_W-1:0] TEN_PREFIX = 17'h0f000;

    // One classified word: a timer tick or a command with its flags.
    typedef struct packed {
        logic               is_cmd;
        logic [FLAGS_W-1:0] pend;
        logic [DATA_W-1:0]  data;
        logic               sda;
    } item_t;

endpackage

>>> rtl/i2c_master_bit_sequencer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2c_master_bit_sequencer: I2C master bit sequencer, 7-bit and 10-bit address
// Input words are timer ticks or commands (tuser). A command starts a
// sequence of start or repeated start, address framing, MSB-first bits,
// acknowledge slots and an optional stop; ticks step it one SCL half period
// at a time. Every input word yields exactly one result word that carries
// the SCL/SDA line state, the command status, busy and the interrupt report.
// The configuration port sets enable, interrupt mask and half period; it is
// to be written by the user only while no word is in flight (the block does
// not enforce this) and takes effect from the next edge. A word accepted at
// an edge passes the input stage, the queue and the core output register,
// where its result word becomes valid. Throughput is one word per cycle while
// m_tready stays high; the core computes the step for a word combinationally.
// Reset (aresetn low, synchronous) empties the input stage, the queue and the
// output register and returns the phase machine to idle with SCL and SDA
// driven high. When the receiver holds m_tready low, the output register
// holds its word, the core stops and the queue and input stage fill, after
// which s_tready drops; no word is lost.
// ----------------------------------------------------------------------------
module i2c_master_bit_sequencer
    import i2cms_pkg::*;
#(
    parameter int SHIFT_WIDTH = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // Configuration write port.
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wr_data,
    // Input word channel.
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // cmd_start, cmd_restart, cmd_stop, cmd_read, cmd_ten_bit, cmd_data[9:0],
    // sda_in
    input  logic [S_TDATA_W-1:0]  s_tdata,
    // func
    input  logic                  s_tuser,
    // Result word channel.
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // scl_level, sda_level, sda_drive, cmd_status[1:0], busy_flag, irq_valid,
    // irq_flags[4:0], read_data[7:0], zero fill
    output logic [M_TDATA_W-1:0]  m_tdata
);

    logic  fr_valid;
    logic  fr_ready;
    item_t fr_item;
    logic  q_valid;
    logic  q_ready;
    item_t q_item;

    i2cms_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_valid  (fr_valid),
        .q_ready  (fr_ready),
        .q_item   (fr_item)
    );

    i2cms_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (fr_valid),
        .in_ready  (fr_ready),
        .in_item   (fr_item),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_item  (q_item)
    );

    i2cms_core #(
        .SHIFT_WIDTH (SHIFT_WIDTH)
    ) u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (q_valid),
        .in_ready    (q_ready),
        .in_item     (q_item),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

`ifndef ASSERT_OFF
    // A finished sequence always reports busy cleared.
    a_irq_not_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[6] |-> !m_tdata[5])
        else $error("interrupt reported while busy");

    // A refused command never ends a sequence.
    a_refused_no_irq: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[4:3] != ST_OK) |-> !m_tdata[6])
        else $error("refused command reported an interrupt");

    // Flags are only reported together with the interrupt.
    a_flags_with_irq: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[6] |-> (m_tdata[11:7] == '0))
        else $error("interrupt flags without interrupt");

    // A refused command while disabled leaves busy clear.
    a_disabled_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[4:3] == ST_DISABLED) && !$past(m_tdata[5])
            && $past(m_tvalid) |-> !m_tdata[5])
        else $error("disabled command set busy");
`endif

endmodule

>>> rtl/i2cms_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cms_front: input stage
// Accepts stream words, splits them into tick or command, gathers the command
// flags into one pending-flag vector and hands the result to the queue.
// ----------------------------------------------------------------------------
module i2cms_front
    import i2cms_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic                 s_tuser,
    output logic                 q_valid,
    input  logic                 q_ready,
    output item_t                q_item
);

    logic  fr_valid_reg;
    logic  fr_valid_next;
    item_t fr_item_reg;
    item_t fr_item_next;
    logic  s_fire;

    // The stage takes a new word whenever it is empty or hands its word on.
    assign s_tready = !fr_valid_reg || q_ready;
    assign s_fire   = s_tvalid && s_tready;

    // Classify the incoming word.
    always_comb begin
        fr_item_next        = fr_item_reg;
        if (s_fire) begin
            fr_item_next.is_cmd = s_tuser;
            fr_item_next.pend   = s_tdata[FLAGS_W-1:0];
            fr_item_next.data   = s_tdata[FLAGS_W +: DATA_W];
            fr_item_next.sda    = s_tdata[FLAGS_W + DATA_W];
        end
    end

    always_comb begin
        if (s_fire) begin
            fr_valid_next = 1'b1;
        end else if (q_ready) begin
            fr_valid_next = 1'b0;
        end else begin
            fr_valid_next = fr_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fr_valid_reg <= 1'b0;
        end else begin
            fr_valid_reg <= fr_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        fr_item_reg <= fr_item_next;
    end

    assign q_valid = fr_valid_reg;
    assign q_item  = fr_item_reg;

endmodule

>>> rtl/i2cms_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cms_queue: short word queue
// A small register FIFO that decouples the front stage from the sequencer
// core so that either side can stall on its own.
// ----------------------------------------------------------------------------
module i2cms_queue
    import i2cms_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  in_valid,
    output logic  in_ready,
    input  item_t in_item,
    output logic  out_valid,
    input  logic  out_ready,
    output item_t out_item
);

    item_t           slot_reg [QDEPTH];
    logic [Q_AW-1:0] wr_ptr_reg;
    logic [Q_AW-1:0] wr_ptr_next;
    logic [Q_AW-1:0] rd_ptr_reg;
    logic [Q_AW-1:0] rd_ptr_next;
    logic [Q_CW-1:0] count_reg;
    logic [Q_CW-1:0] count_next;
    logic            push;
    logic            pop;

    assign in_ready  = (count_reg != Q_CW'(QDEPTH));
    assign out_valid = (count_reg != '0);
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;
    assign out_item  = slot_reg[rd_ptr_reg];

    // Pointer and fill bookkeeping.
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == Q_AW'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == Q_AW'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage slots.
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

>>> rtl/i2cms_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cms_core: sequencer core
// Holds the configuration and the bus phase machine. Each queued word is a
// command, which starts a sequence unless refused, or a timer tick, which steps
// the phase machine after a full half period. One result word per queued word.
// ----------------------------------------------------------------------------
module i2cms_core
    import i2cms_pkg::*;
#(
    parameter int SHIFT_WIDTH = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wr_data,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  item_t                 in_item,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata
);

    localparam int SW = SHIFT_WIDTH;

    // Phase codes.
    localparam logic [2:0] PH_IDLE     = 3'd0;
    localparam logic [2:0] PH_RESTART2 = 3'd1;
    localparam logic [2:0] PH_BIT_RISE = 3'd2;
    localparam logic [2:0] PH_BIT_FALL = 3'd3;
    localparam logic [2:0] PH_ACK_RISE = 3'd4;
    localparam logic [2:0] PH_ACK_FALL = 3'd5;
    localparam logic [2:0] PH_AFTER    = 3'd6;
    localparam logic [2:0] PH_STOP2    = 3'd7;

    // Configuration registers.
    logic               enable_reg;
    logic [FLAGS_W-1:0] mask_reg;
    logic [HALF_W-1:0]  half_reg;

    // Sequencer state.
    logic [2:0]         phase_reg,  phase_next;
    logic [FLAGS_W-1:0] pend_reg,   pend_next;
    logic [SW-1:0]      shift_reg,  shift_next;
    logic [SW-1:0]      bsel_reg,   bsel_next;
    logic [FLAGS_W-1:0] ev_reg,     ev_next;
    logic               busy_reg,   busy_next;
    logic [HALF_W-1:0]  tick_reg,   tick_next;
    logic               scl_reg,    scl_next;
    logic               sda_reg,    sda_next;
    logic               drv_reg,    drv_next;

    // Output register.
    logic                 m_valid_reg, m_valid_next;
    logic [M_TDATA_W-1:0] m_data_reg,  m_data_next;

    logic                 fire;
    logic [STATUS_W-1:0]  status;
    logic                 rep_valid;
    logic [FLAGS_W-1:0]   rep_flags;
    logic                 do_frame;
    logic                 do_rise;
    logic                 do_finish;
    logic [HALF_W-1:0]    half_eff;
    logic [HALF_W:0]      tick_inc;
    logic [FRAME_W-1:0]   frame_src;
    logic [FRAME_W-1:0]   frame_val;
    logic                 frame_rd;

    assign in_ready = !m_valid_reg || m_tready;
    assign fire     = in_valid && in_ready;
    assign half_eff = (half_reg == '0) ? HALF_W'(1) : half_reg;
    assign tick_inc = {1'b0, tick_reg} + 1'b1;

    // Configuration writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enable_reg <= 1'b0;
            mask_reg   <= '0;
            half_reg   <= HALF_W'(10);
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_ENABLE: enable_reg <= cfg_wr_data[0];
                CFG_MASK:   mask_reg   <= cfg_wr_data[FLAGS_W-1:0];
                CFG_HALF:   half_reg   <= cfg_wr_data[HALF_W-1:0];
                default:    ;
            endcase
        end
    end

    // Next-state logic of the phase machine for one word.
    always_comb begin
        phase_next = phase_reg;
        pend_next  = pend_reg;
        shift_next = shift_reg;
        bsel_next  = bsel_reg;
        ev_next    = ev_reg;
        busy_next  = busy_reg;
        tick_next  = tick_reg;
        scl_next   = scl_reg;
        sda_next   = sda_reg;
        drv_next   = drv_reg;
        status     = ST_OK;
        rep_valid  = 1'b0;
        rep_flags  = '0;
        do_frame   = 1'b0;
        do_rise    = 1'b0;
        do_finish  = 1'b0;
        frame_src  = '0;
        frame_val  = '0;
        frame_rd   = 1'b0;

        if (in_item.is_cmd) begin
            // Command: refused when disabled or busy.
            if (!enable_reg) begin
                status = ST_DISABLED;
            end else if (busy_reg) begin
                status = ST_BUSY;
            end else begin
                busy_next = 1'b1;
                pend_next = in_item.pend;
                ev_next   = '0;
                tick_next = '0;
                if (in_item.pend[PD_READ] &&
                    !(in_item.pend[PD_START] || in_item.pend[PD_RESTART])) begin
                    shift_next = '0;
                end else begin
                    frame_src  = FRAME_W'(in_item.data);
                    shift_next = frame_src[SW-1:0];
                end
                bsel_next = in_item.pend[PD_TEN] ? (SW'(1) << (SW - 1))
                                                 : SW'(FRAME_W'(17'h00080));
                if (in_item.pend[PD_START]) begin
                    pend_next[PD_START]   = 1'b0;
                    pend_next[PD_RESTART] = 1'b0;
                    scl_next = 1'b0;
                    sda_next = 1'b0;
                    drv_next = 1'b1;
                    ev_next[EV_STARTED] = 1'b1;
                    do_frame   = 1'b1;
                    phase_next = PH_BIT_RISE;
                end else if (in_item.pend[PD_RESTART]) begin
                    pend_next[PD_RESTART] = 1'b0;
                    scl_next = 1'b1;
                    sda_next = 1'b1;
                    drv_next = 1'b1;
                    ev_next[EV_STARTED] = 1'b1;
                    phase_next = PH_RESTART2;
                end else begin
                    do_rise = 1'b1;
                end
            end
        end else if (phase_reg != PH_IDLE) begin
            // Tick: step once a full half period has gone by.
            if (tick_inc >= {1'b0, half_eff}) begin
                tick_next = '0;
                unique case (phase_reg)
                    PH_RESTART2: begin
                        scl_next   = 1'b0;
                        sda_next   = 1'b0;
                        drv_next   = 1'b1;
                        do_frame   = 1'b1;
                        phase_next = PH_BIT_RISE;
                    end
                    PH_BIT_RISE: begin
                        do_rise = 1'b1;
                    end
                    PH_BIT_FALL: begin
                        if (pend_reg[PD_READ] && in_item.sda) begin
                            shift_next = shift_reg | bsel_reg;
                        end
                        scl_next  = 1'b0;
                        bsel_next = bsel_reg >> 1;
                        if (bsel_next == '0 || bsel_next == SW'(FRAME_W'(17'h00080))) begin
                            if (ev_reg[EV_STARTED]) begin
                                if (pend_reg[PD_TEN]) begin
                                    pend_next[PD_TEN] = 1'b0;
                                    ev_next[EV_TEN]   = 1'b1;
                                end else begin
                                    ev_next[EV_ADDR] = 1'b1;
                                end
                            end else begin
                                ev_next[EV_TXE] = 1'b1;
                            end
                            phase_next = PH_ACK_RISE;
                        end else begin
                            phase_next = PH_BIT_RISE;
                        end
                    end
                    PH_ACK_RISE: begin
                        scl_next   = 1'b1;
                        sda_next   = 1'b1;
                        drv_next   = 1'b0;
                        phase_next = PH_ACK_FALL;
                    end
                    PH_ACK_FALL: begin
                        sda_next = 1'b1;
                        drv_next = 1'b1;
                        if (in_item.sda) begin
                            // No acknowledge from the target.
                            ev_next[EV_NACK] = 1'b1;
                            if (pend_reg[PD_STOP]) begin
                                scl_next   = 1'b0;
                                phase_next = PH_AFTER;
                            end else begin
                                scl_next  = 1'b1;
                                do_finish = 1'b1;
                            end
                        end else begin
                            scl_next   = 1'b0;
                            phase_next = (bsel_reg != '0) ? PH_BIT_RISE : PH_AFTER;
                        end
                    end
                    PH_AFTER: begin
                        if (pend_reg[PD_STOP]) begin
                            scl_next   = 1'b1;
                            sda_next   = 1'b0;
                            drv_next   = 1'b1;
                            phase_next = PH_STOP2;
                        end else begin
                            do_finish = 1'b1;
                        end
                    end
                    PH_STOP2: begin
                        scl_next  = 1'b1;
                        sda_next  = 1'b1;
                        drv_next  = 1'b1;
                        do_finish = 1'b1;
                    end
                    default: begin
                        phase_next = PH_IDLE;
                    end
                endcase
            end else begin
                tick_next = tick_inc[HALF_W-1:0];
            end
        end

        // Address framing, seven-bit or ten-bit with the 11110 prefix.
        if (do_frame) begin
            frame_src = FRAME_W'(shift_next);
            frame_rd  = pend_next[PD_READ];
            if (pend_next[PD_TEN]) begin
                frame_val = TEN_PREFIX | (FRAME_W'(frame_src[9:8]) << 9)
                          | FRAME_W'(frame_src[7:0]) | (FRAME_W'(frame_rd) << 8);
            end else begin
                frame_val = (frame_src << 1) | FRAME_W'(frame_rd);
            end
            pend_next[PD_READ] = 1'b0;
            shift_next         = frame_val[SW-1:0];
        end

        // Rising SCL edge of a data bit: drive the current bit, or release SDA on reads.
        if (do_rise) begin
            scl_next = 1'b1;
            if (pend_next[PD_READ]) begin
                sda_next = 1'b1;
                drv_next = 1'b0;
            end else begin
                sda_next = ((shift_next & bsel_next) != '0);
                drv_next = 1'b1;
            end
            phase_next = PH_BIT_FALL;
        end

        // End of sequence: report enabled flags and go idle.
        if (do_finish) begin
            rep_valid  = 1'b1;
            rep_flags  = ev_next & mask_reg;
            busy_next  = 1'b0;
            ev_next    = '0;
            pend_next  = '0;
            phase_next = PH_IDLE;
        end
    end

    // Result word, fields from the highest bit down.
    always_comb begin
        m_data_next = m_data_reg;
        if (fire) begin
            m_data_next = {4'b0, shift_next[RDATA_W-1:0], rep_flags, rep_valid,
                           busy_next, status, drv_next,
                           (drv_next ? sda_next : 1'b1), scl_next};
        end
        if (fire) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_IDLE;
            pend_reg    <= '0;
            shift_reg   <= '0;
            bsel_reg    <= '0;
            ev_reg      <= '0;
            busy_reg    <= 1'b0;
            tick_reg    <= '0;
            scl_reg     <= 1'b1;
            sda_reg     <= 1'b1;
            drv_reg     <= 1'b1;
            m_valid_reg <= 1'b0;
        end else begin
            if (fire) begin
                phase_reg <= phase_next;
                pend_reg  <= pend_next;
                shift_reg <= shift_next;
                bsel_reg  <= bsel_next;
                ev_reg    <= ev_next;
                busy_reg  <= busy_next;
                tick_reg  <= tick_next;
                scl_reg   <= scl_next;
                sda_reg   <= sda_next;
                drv_reg   <= drv_next;
            end
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule
